FILE: sv/mlba_pkg.sv
// Package for the multilook box average: sizes, register indexes and control structs.
`default_nettype none

package mlba_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int SUM_BITS       = 40;
    localparam int MAX_LINE_WIDTH = 4096;
    localparam int MAX_LOOKS      = 16;

    localparam int COL_BITS   = $clog2(MAX_LINE_WIDTH);
    localparam int WIDTH_BITS = COL_BITS + 1;
    localparam int LOOK_BITS  = $clog2(MAX_LOOKS) + 1;
    localparam int CNT_BITS   = LOOK_BITS - 1;
    localparam int PROD_BITS  = 2 * LOOK_BITS;
    localparam int STEP_BITS  = $clog2(SUM_BITS);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = WIDTH_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOOKS   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AZIMUTH_LOOKS = 2'd2;

    localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(1024);
    localparam logic [LOOK_BITS-1:0]  LOOKS_RESET      = LOOK_BITS'(4);

    typedef struct packed {
        logic accept;
        logic rd_write;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic group_done;
        logic first_row;
        logic last_row;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/multilook_box_average.sv
// A word that does not close a range group, or closes one on a first row that is not the last row,
// is accepted with no further step. A word that closes a range group on a later row adds a step
// (line store read, add, write). A word that completes a block also waits on the 40-step divider.
// The output register lets the next word be taken while a result waits downstream.
// Reset is synchronous and active low: registers return to defaults, the position to zero;
// the line store is not cleared and has no reset pass.
`default_nettype none

module multilook_box_average
    import mlba_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [SAMPLE_BITS-1:0]   s_sample,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [SAMPLE_BITS-1:0]   m_average,
    output logic                          m_line_end
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mlba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mlba_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_average  (m_average),
        .m_line_end (m_line_end),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire

FILE: sv/mlba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mlba_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 40
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/mlba_div.sv
// Restoring signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module mlba_div
    import mlba_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [SUM_BITS-1:0]    dividend,
    input  wire logic [PROD_BITS-1:0]   divisor,
    output logic                        done,
    output logic      [SAMPLE_BITS-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 neg_reg;
    logic [SUM_BITS-1:0]  num_reg;
    logic [PROD_BITS-1:0] rem_reg;
    logic [PROD_BITS-1:0] div_reg;

    logic [PROD_BITS:0]   trial;
    logic [PROD_BITS:0]   diff;
    logic                 qbit;
    logic [SUM_BITS-1:0]  q_full;

    // The partial remainder stays below the divisor, so it always fits its register.
    assign trial  = {rem_reg, num_reg[SUM_BITS-1]};
    assign diff   = trial - {1'b0, div_reg};
    assign qbit   = ~diff[PROD_BITS];
    assign q_full = neg_reg ? (~num_reg + SUM_BITS'(1)) : num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_BITS'(SUM_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_BITS-1];
            num_reg <= dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= {num_reg[SUM_BITS-2:0], qbit};
            rem_reg <= qbit ? diff[PROD_BITS-1:0] : trial[PROD_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_full[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

FILE: sv/mlba_datapath.sv
// Datapath: configuration registers, stream position, line store, divider and output register.
`default_nettype none

module mlba_datapath
    import mlba_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]   s_sample,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [SAMPLE_BITS-1:0]   m_average,
    output logic                          m_line_end,
    input  wire ctrl_cmd_t                cmd,
    output dp_status_t                    status
);

    logic [WIDTH_BITS-1:0] line_width_reg;
    logic [LOOK_BITS-1:0]  range_looks_reg;
    logic [LOOK_BITS-1:0]  azimuth_looks_reg;

    logic [COL_BITS-1:0]   col_reg;
    logic [COL_BITS-1:0]   grp_idx_reg;
    logic [COL_BITS-1:0]   save_col_reg;
    logic [CNT_BITS-1:0]   row_reg;
    logic [CNT_BITS-1:0]   look_reg;
    logic [SUM_BITS-1:0]   range_sum_reg;
    logic [SUM_BITS-1:0]   gsum_hold_reg;
    logic                  line_end_hold_reg;

    logic                  m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_average_reg;
    logic                  m_line_end_reg;

    logic [SUM_BITS-1:0]   sample_ext;
    logic [SUM_BITS-1:0]   group_sum;
    logic [SUM_BITS-1:0]   rd_data;
    logic [SUM_BITS-1:0]   rd_sum;
    logic                  group_done;
    logic                  line_done;
    logic                  last_row;
    logic                  first_row;
    logic                  line_end_now;
    logic [PROD_BITS-1:0]  look_product;
    logic                  ram_we;
    logic [COL_BITS-1:0]   ram_waddr;
    logic [SUM_BITS-1:0]   ram_wdata;
    logic [SUM_BITS-1:0]   div_dividend;
    logic                  div_done;
    logic [SAMPLE_BITS-1:0] div_quotient;
    logic [WIDTH_BITS-1:0] cfg_width_val;
    logic [LOOK_BITS-1:0]  cfg_look_val;

    assign sample_ext   = {{(SUM_BITS - SAMPLE_BITS){s_sample[SAMPLE_BITS-1]}}, s_sample};
    assign group_sum    = range_sum_reg + sample_ext;
    assign rd_sum       = rd_data + gsum_hold_reg;
    assign group_done   = (LOOK_BITS'(look_reg) + LOOK_BITS'(1)) >= range_looks_reg;
    assign line_done    = (WIDTH_BITS'(col_reg) + WIDTH_BITS'(1)) >= line_width_reg;
    assign last_row     = (LOOK_BITS'(row_reg) + LOOK_BITS'(1)) >= azimuth_looks_reg;
    assign first_row    = (row_reg == '0);
    assign line_end_now = (WIDTH_BITS'(col_reg) + WIDTH_BITS'(range_looks_reg))
                          >= line_width_reg;
    assign look_product = PROD_BITS'(range_looks_reg) * PROD_BITS'(azimuth_looks_reg);

    // Zero stores as one, values above the maximum as the maximum; looks use only cfg_data[4:0].
    always_comb begin
        if (cfg_data == '0) begin
            cfg_width_val = WIDTH_BITS'(1);
        end else if (cfg_data > CFG_DATA_BITS'(MAX_LINE_WIDTH)) begin
            cfg_width_val = WIDTH_BITS'(MAX_LINE_WIDTH);
        end else begin
            cfg_width_val = cfg_data[WIDTH_BITS-1:0];
        end
        if (cfg_data[LOOK_BITS-1:0] == '0) begin
            cfg_look_val = LOOK_BITS'(1);
        end else if (cfg_data[LOOK_BITS-1:0] > LOOK_BITS'(MAX_LOOKS)) begin
            cfg_look_val = LOOK_BITS'(MAX_LOOKS);
        end else begin
            cfg_look_val = cfg_data[LOOK_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg    <= LINE_WIDTH_RESET;
            range_looks_reg   <= LOOKS_RESET;
            azimuth_looks_reg <= LOOKS_RESET;
            col_reg           <= '0;
            grp_idx_reg       <= '0;
            row_reg           <= '0;
            look_reg          <= '0;
            range_sum_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINE_WIDTH:    line_width_reg    <= cfg_width_val;
                REG_RANGE_LOOKS:   range_looks_reg   <= cfg_look_val;
                REG_AZIMUTH_LOOKS: azimuth_looks_reg <= cfg_look_val;
                default: ;
            endcase
            // Any valid register write restarts the stream position.
            if (cfg_index == REG_LINE_WIDTH || cfg_index == REG_RANGE_LOOKS
                || cfg_index == REG_AZIMUTH_LOOKS) begin
                col_reg       <= '0;
                grp_idx_reg   <= '0;
                row_reg       <= '0;
                look_reg      <= '0;
                range_sum_reg <= '0;
            end
        end else if (cmd.accept) begin
            if (group_done) begin
                range_sum_reg <= '0;
                look_reg      <= '0;
                grp_idx_reg   <= grp_idx_reg + COL_BITS'(1);
            end else begin
                range_sum_reg <= group_sum;
                look_reg      <= look_reg + CNT_BITS'(1);
            end
            if (line_done) begin
                col_reg       <= '0;
                grp_idx_reg   <= '0;
                range_sum_reg <= '0;
                look_reg      <= '0;
                row_reg       <= last_row ? '0 : row_reg + CNT_BITS'(1);
            end else begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // Context of the word whose range group has just closed.
    always_ff @(posedge aclk) begin
        if (cmd.accept && group_done) begin
            save_col_reg      <= grp_idx_reg;
            gsum_hold_reg     <= group_sum;
            line_end_hold_reg <= line_end_now;
        end
    end

    // The first row of a group writes the column sum directly; later rows read, add and write.
    assign ram_we       = (cmd.accept && group_done && first_row) || cmd.rd_write;
    assign ram_waddr    = cmd.rd_write ? save_col_reg : grp_idx_reg;
    assign ram_wdata    = cmd.rd_write ? rd_sum : group_sum;
    assign div_dividend = cmd.rd_write ? rd_sum : group_sum;

    mlba_ram #(
        .DEPTH (MAX_LINE_WIDTH),
        .WIDTH (SUM_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (grp_idx_reg),
        .rd_data (rd_data)
    );

    mlba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (look_product),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_average_reg  <= div_quotient;
            m_line_end_reg <= line_end_hold_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_average  = m_average_reg;
    assign m_line_end = m_line_end_reg;

    assign status.group_done = group_done;
    assign status.first_row  = first_row;
    assign status.last_row   = last_row;
    assign status.div_done   = div_done;
    assign status.out_free   = ~m_valid_reg | m_ready;

endmodule

`default_nettype wire

FILE: sv/mlba_ctrl.sv
// Controller: sequences the accept, read-modify-write, divide and output steps of each word.
`default_nettype none

module mlba_ctrl
    import mlba_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   last_row_reg, last_row_next;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        last_row_next = last_row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid & ready_reg;
                if (cmd.accept && status.group_done) begin
                    if (!status.first_row) begin
                        last_row_next = status.last_row;
                        state_next    = ST_READ;
                    end else if (status.last_row) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_write = 1'b1;
                if (last_row_reg) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // Ready stays low while reset is held; once reset is released it is registered high from the idle state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ready_reg    <= 1'b0;
            last_row_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            last_row_reg <= last_row_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire
